// File: hw/rtl/mwf_pkg.sv
// Shared types and codes for the mutex with a FIFO wait queue.
`timescale 1ns / 1ps

package mwf_pkg;

  localparam int TaskW   = 4;
  localparam int StatusW = 4;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_DELETE  = 2'd2
  } action_t;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED         = 4'd0,
    ST_QUEUED          = 4'd1,
    ST_ALREADY_OWNER   = 4'd2,
    ST_QUEUE_FULL      = 4'd3,
    ST_RELEASE_REFUSED = 4'd4,
    ST_FREED           = 4'd5,
    ST_HANDED_OVER     = 4'd6,
    ST_DELETED         = 4'd7,
    ST_DELETE_REFUSED  = 4'd8
  } status_t;

  // request word
  typedef struct packed {
    action_t          action;
    logic [TaskW-1:0] task_id;
  } req_t;

  // result word
  typedef struct packed {
    status_t          status;
    logic [TaskW-1:0] new_owner;
    logic             owner_valid;
  } rsp_t;

endpackage

// File: hw/rtl/mwf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mwf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/mwf_core.sv
// Request sequencer: owner and ring pointers, read-modify-write of the waiter ring.
`timescale 1ns / 1ps

module mwf_core
  import mwf_pkg::*;
#(
  parameter int WAIT_DEPTH = 8,
  localparam int IW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
  localparam int CW = $clog2(WAIT_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output rsp_t             result,
  // waiter ring port
  output logic             ring_we,
  output logic [IW-1:0]    ring_waddr,
  output logic [TaskW-1:0] ring_wdata,
  output logic [IW-1:0]    ring_raddr,
  input  logic [TaskW-1:0] ring_rdata
);

  logic             pending;
  req_t             req_q;
  logic             held, held_next;
  logic [TaskW-1:0] owner, owner_next;
  logic [IW-1:0]    head, head_next;
  logic [IW-1:0]    tail, tail_next;
  logic [CW-1:0]    count, count_next;
  status_t          status;
  logic             accept;

  assign accept = start && !pending;
  assign busy   = pending;

  // head is always being read, so the oldest waiter is ready in the execute cycle
  assign ring_raddr = head;
  assign ring_waddr = tail;
  assign ring_wdata = req_q.task_id;

  // execute: decide the request against the registered state
  always_comb begin
    held_next  = held;
    owner_next = owner;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ring_we    = 1'b0;
    status     = ST_RELEASE_REFUSED;
    case (req_q.action)
      ACT_ACQUIRE: begin
        if (!held) begin
          held_next  = 1'b1;
          owner_next = req_q.task_id;
          status     = ST_GRANTED;
        end else if (owner == req_q.task_id) begin
          status = ST_ALREADY_OWNER;
        end else if (count >= CW'(WAIT_DEPTH)) begin
          status = ST_QUEUE_FULL;
        end else begin
          ring_we    = pending;
          tail_next  = (tail == IW'(WAIT_DEPTH - 1)) ? '0 : tail + 1'b1;
          count_next = count + 1'b1;
          status     = ST_QUEUED;
        end
      end
      ACT_RELEASE: begin
        if (!held || owner != req_q.task_id) begin
          status = ST_RELEASE_REFUSED;
        end else if (count == '0) begin
          held_next  = 1'b0;
          owner_next = '0;
          status     = ST_FREED;
        end else begin
          owner_next = ring_rdata;
          head_next  = (head == IW'(WAIT_DEPTH - 1)) ? '0 : head + 1'b1;
          count_next = count - 1'b1;
          status     = ST_HANDED_OVER;
        end
      end
      ACT_DELETE: begin
        if (held) begin
          status = ST_DELETE_REFUSED;
        end else begin
          owner_next = '0;
          head_next  = '0;
          tail_next  = '0;
          count_next = '0;
          status     = ST_DELETED;
        end
      end
      default: begin
        status = ST_RELEASE_REFUSED;
      end
    endcase
  end

  // state, request capture and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      done    <= 1'b0;
      held    <= 1'b0;
      owner   <= '0;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
    end else begin
      done <= pending;
      if (accept) begin
        pending <= 1'b1;
        req_q   <= req;
      end
      if (pending) begin
        pending            <= 1'b0;
        held               <= held_next;
        owner              <= owner_next;
        head               <= head_next;
        tail               <= tail_next;
        count              <= count_next;
        result.status      <= status;
        result.new_owner   <= held_next ? owner_next : '0;
        result.owner_valid <= held_next;
      end
    end
  end

  // every accepted request yields one result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("request produced no result");

  // free mutex never has waiters
  a_free_empty: assert property (@(posedge clk) disable iff (rst)
    !held |-> count == '0)
    else $error("waiters queued on a free mutex");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(WAIT_DEPTH))
    else $error("waiter count beyond ring depth");

  // reported owner matches held state after the request
  a_result_owner: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.owner_valid == held) && (!held || result.new_owner == owner))
    else $error("result disagrees with owner state");

  a_ring_write: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> pending && held && count < CW'(WAIT_DEPTH))
    else $error("ring written outside an accepted queueing");

endmodule

// File: hw/rtl/mutex_with_fifo_waiters_top.sv
// Top level of the hardware mutex with a FIFO queue of waiting tasks.
`timescale 1ns / 1ps

// Usage:
//   A request word (action, task_id) is taken at a rising edge where start
//   is high and busy is low. busy stays high for the one cycle in which the
//   request is executed against the owner registers and the waiter ring.
//   The result word (status, new_owner, owner_valid) appears on result for
//   exactly one cycle with done high, registered at the end of the execute
//   cycle. No new request is taken while one executes: the waiter ring lives
//   in a RAM with a registered read port, so the oldest waiter read at the
//   head pointer is only available in the cycle after acceptance, and the
//   ring write and pointer update land at the end of that cycle.
//   Acquire of a held mutex by a non-owner appends the task at the tail
//   unless the ring is full; release by the owner pops the head waiter as
//   new owner, or frees the mutex if none. Delete is refused while held and otherwise resets owner and pointers.
//   Synchronous reset (rst) frees the mutex and empties the queue at once;
//   ring contents are not cleared, as only written entries are ever read.
//   The receiver cannot stall: done is a strobe and must be sampled.

module mutex_with_fifo_waiters_top
  import mwf_pkg::*;
#(
  parameter int WAIT_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t result
);

  localparam int IW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

  logic             ring_we;
  logic [IW-1:0]    ring_waddr;
  logic [IW-1:0]    ring_raddr;
  logic [TaskW-1:0] ring_wdata;
  logic [TaskW-1:0] ring_rdata;

  mwf_core #(
    .WAIT_DEPTH(WAIT_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .ring_we   (ring_we),
    .ring_waddr(ring_waddr),
    .ring_wdata(ring_wdata),
    .ring_raddr(ring_raddr),
    .ring_rdata(ring_rdata)
  );

  // waiter ring
  mwf_ram #(
    .WIDTH(TaskW),
    .DEPTH(WAIT_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_waddr),
    .wdata(ring_wdata),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

endmodule
